[rtl/tms_pkg.sv]
// Package for the tone melody sequencer: request codes, item and result
// structs and note store sizing. No dependencies.
`default_nettype none

package tms_pkg;

  // Note store depth; a power of two so slot numbers wrap by truncation.
  localparam int unsigned NOTE_DEPTH = 64;
  localparam int unsigned PTR_W      = $clog2(NOTE_DEPTH);

  // Field widths of one input item and one result item.
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned PER_W  = 16;
  localparam int unsigned DUR_W  = 16;
  localparam int unsigned HIGH_W = 15;
  localparam int unsigned NOTE_W = PER_W + DUR_W;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_START = 2'd2,
    REQ_STOP  = 2'd3
  } req_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [IDX_W-1:0] note_index;
    logic [PER_W-1:0] note_period;
    logic [DUR_W-1:0] note_duration;
  } item_t;

  typedef struct packed {
    logic              tone_on;
    logic [PER_W-1:0]  tone_period;
    logic [HIGH_W-1:0] tone_high_time;
    logic              playing;
    logic              song_ended;
  } result_t;

  // Map a note index onto a store slot, wrapping modulo the depth.
  function automatic logic [PTR_W-1:0] slot_of(logic [IDX_W-1:0] idx);
    return PTR_W'(idx);
  endfunction

endpackage

`default_nettype wire

[rtl/tms_if.sv]
// Valid/ready channel interfaces for request items and result items.
// Depends on tms_pkg for the field widths.
`default_nettype none

interface tms_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic [tms_pkg::IDX_W-1:0] note_index;
  logic [tms_pkg::PER_W-1:0] note_period;
  logic [tms_pkg::DUR_W-1:0] note_duration;

  modport source (output valid, req_type, note_index, note_period, note_duration,
                  input ready);
  modport sink (input valid, req_type, note_index, note_period, note_duration,
                output ready);
endinterface

interface tms_res_if;
  logic                       valid;
  logic                       ready;
  logic                       tone_on;
  logic [tms_pkg::PER_W-1:0]  tone_period;
  logic [tms_pkg::HIGH_W-1:0] tone_high_time;
  logic                       playing;
  logic                       song_ended;

  modport source (output valid, tone_on, tone_period, tone_high_time, playing,
                  song_ended, input ready);
  modport sink (input valid, tone_on, tone_period, tone_high_time, playing,
                song_ended, output ready);
endinterface

`default_nettype wire

[rtl/tms_note_mem.sv]
// Note store: one write port and one read port with registered read data.
// Depends on tms_pkg for depth and word width.
`default_nettype none

module tms_note_mem (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [tms_pkg::PTR_W-1:0]  waddr_i,
  input  wire logic [tms_pkg::NOTE_W-1:0] wdata_i,
  input  wire logic                       re_i,
  input  wire logic [tms_pkg::PTR_W-1:0]  raddr_i,
  output logic      [tms_pkg::NOTE_W-1:0] rdata_o
);
  import tms_pkg::*;

  logic [NOTE_W-1:0] mem_q [NOTE_DEPTH];
  logic [NOTE_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data register holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/tms_seq_core.sv]
// Sequencer state and its next-state logic for one request item.
// Depends on tms_pkg for the item and result structs.
`default_nettype none

module tms_seq_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       adv_i,
  input  wire tms_pkg::item_t             item_i,
  input  wire logic [tms_pkg::NOTE_W-1:0] entry_i,
  output logic      [tms_pkg::PTR_W-1:0]  rptr_next_o,
  output tms_pkg::result_t                result_o
);
  import tms_pkg::*;

  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [DUR_W-1:0] ticks_q, ticks_d;
  logic             active_q, active_d;
  logic             tone_q, tone_d;
  logic [PER_W-1:0] period_q, period_d;
  logic             ended;
  logic             load;
  logic [PTR_W-1:0] load_slot;
  logic [PER_W-1:0] entry_per;
  logic [DUR_W-1:0] entry_dur;

  assign entry_per = entry_i[PER_W-1:0];
  assign entry_dur = entry_i[NOTE_W-1:PER_W];

  // Next state for the item held in the input stage.
  always_comb begin
    rptr_d    = rptr_q;
    ticks_d   = ticks_q;
    active_d  = active_q;
    tone_d    = tone_q;
    period_d  = period_q;
    ended     = 1'b0;
    load      = 1'b0;
    load_slot = rptr_q;
    unique case (req_e'(item_i.req_type))
      REQ_TICK: begin
        if (active_q) begin
          if (ticks_q <= DUR_W'(1)) begin
            load = 1'b1;
          end else begin
            ticks_d = ticks_q - DUR_W'(1);
          end
        end
      end
      REQ_WRITE: begin
      end
      REQ_START: begin
        active_d  = 1'b1;
        load      = 1'b1;
        load_slot = slot_of(item_i.note_index);
      end
      REQ_STOP: begin
        active_d = 1'b0;
        tone_d   = 1'b0;
        ticks_d  = '0;
      end
      default: begin
      end
    endcase

    // Sound the fetched note; a zero duration is the end of the song.
    if (load) begin
      tone_d = 1'b0;
      if (entry_dur == '0) begin
        active_d = 1'b0;
        ticks_d  = '0;
        ended    = 1'b1;
      end else begin
        if (entry_per != '0) begin
          period_d = entry_per;
          tone_d   = 1'b1;
        end
        rptr_d  = PTR_W'(load_slot + PTR_W'(1));
        ticks_d = entry_dur;
      end
    end
  end

  // State commits only when the item moves on to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q   <= '0;
      ticks_q  <= '0;
      active_q <= 1'b0;
      tone_q   <= 1'b0;
      period_q <= '0;
    end else if (adv_i) begin
      rptr_q   <= rptr_d;
      ticks_q  <= ticks_d;
      active_q <= active_d;
      tone_q   <= tone_d;
      period_q <= period_d;
    end
  end

  // The pointer that the next item will see, for the store read address.
  assign rptr_next_o = adv_i ? rptr_d : rptr_q;

  assign result_o.tone_on        = tone_d;
  assign result_o.tone_period    = period_d;
  assign result_o.tone_high_time = period_d[PER_W-1:1];
  assign result_o.playing        = active_d;
  assign result_o.song_ended     = ended;

  // The tone only sounds while a song is playing.
  assert property (@(posedge clk_i) disable iff (!rst_ni) tone_q |-> active_q)
    else $error("tone enabled while no song is playing");

  // An idle sequencer has no ticks left to count.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !active_q |-> ticks_q == '0)
    else $error("ticks left while no song is playing");

  // A sounding tone always has a nonzero period loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni) tone_q |-> period_q != '0)
    else $error("tone enabled with zero period");

  // The end pulse always leaves the song stopped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   adv_i && ended |=> !active_q)
    else $error("song still playing after end marker");

endmodule

`default_nettype wire

[rtl/tone_melody_sequencer.sv]
// Top level of the tone melody sequencer: input stage, note store,
// sequencer core and result register. Depends on tms_pkg and tms_if.
//
//   Channel  Dir  Transfer when          Payload
//   in_i     in   in_i.valid & ready     req_type, note_index, note_period,
//                                        note_duration
//   out_o    out  out_o.valid & ready    tone_on, tone_period, tone_high_time,
//                                        playing, song_ended
//
// One item is taken every cycle while the result side does not stall; each item
// passes the input stage, then its result is offered from the result register.
// The note store read is issued at the input transfer, using
// the read pointer that the item ahead of it leaves behind.
// Reset clears the sequencer state and both stage valids; the note store is
// not cleared and needs no clearing pass.
// A stalled result holds the input stage, which then stops taking items.
`default_nettype none

module tone_melody_sequencer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tms_req_if.sink   in_i,
  tms_res_if.source out_o
);
  import tms_pkg::*;

  logic             s1_valid_q;
  item_t            s1_item_q;
  logic             out_valid_q;
  result_t          out_q;
  logic             s1_adv;
  logic             in_xfer;
  logic [PTR_W-1:0] rptr_next;
  logic [PTR_W-1:0] raddr;
  logic [NOTE_W-1:0] entry;
  result_t          result;
  logic             is_write;
  logic             is_start;

  // Handshake between the input stage and the result register.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer    = in_i.valid && in_i.ready;

  assign is_write = (req_e'(in_i.req_type) == REQ_WRITE);
  assign is_start = (req_e'(in_i.req_type) == REQ_START);

  // A start reads its own slot; every other item reads the current pointer.
  assign raddr = is_start ? slot_of(in_i.note_index) : rptr_next;

  tms_note_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (in_xfer && is_write),
    .waddr_i (slot_of(in_i.note_index)),
    .wdata_i ({in_i.note_duration, in_i.note_period}),
    .re_i    (in_xfer),
    .raddr_i (raddr),
    .rdata_o (entry)
  );

  tms_seq_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (s1_adv),
    .item_i      (s1_item_q),
    .entry_i     (entry),
    .rptr_next_o (rptr_next),
    .result_o    (result)
  );

  // Stage valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q.req_type      <= in_i.req_type;
      s1_item_q.note_index    <= in_i.note_index;
      s1_item_q.note_period   <= in_i.note_period;
      s1_item_q.note_duration <= in_i.note_duration;
    end
    if (s1_adv) begin
      out_q <= result;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.tone_on        = out_q.tone_on;
  assign out_o.tone_period    = out_q.tone_period;
  assign out_o.tone_high_time = out_q.tone_high_time;
  assign out_o.playing        = out_q.playing;
  assign out_o.song_ended     = out_q.song_ended;

  // A stalled input stage keeps its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   s1_valid_q && !s1_adv |=> s1_valid_q)
    else $error("input stage item lost while stalled");

  // An untaken result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q && !out_o.ready |=> out_valid_q)
    else $error("result dropped before transfer");

  // The input stage never overwrites an item that has not moved on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   in_xfer |-> !s1_valid_q || s1_adv)
    else $error("input transfer while stage is blocked");

endmodule

`default_nettype wire
